[sv/pcmdm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdm_pkg
// Shared constants, register codes and types for the pcm decode / downmix
// hop framer.
// ----------------------------------------------------------------------------
package pcmdm_pkg;

  // default for the widest frame the block is built for
  localparam int MAX_CHANNELS_DEF = 8;

  // depth of the frame queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // quotient bits retired per divider cycle
  localparam int DIV_RADIX_BITS = 4;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BITS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP_LENGTH    = 2'd2;

  // register reset values
  localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd1;
  localparam logic [5:0]  SAMPLE_BITS_RST   = 6'd16;
  localparam logic [15:0] HOP_LENGTH_RST    = 16'd512;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SEND
  } back_state_t;

endpackage

[sv/pcmdm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdm_if
// Valid/ready channels: raw pcm byte words in, mono sample words out.
// ----------------------------------------------------------------------------
interface pcmdm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface pcmdm_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] mono_sample;
  logic              last_of_hop;

  modport source (output valid, mono_sample, last_of_hop, input ready);
  modport sink   (input valid, mono_sample, last_of_hop, output ready);
endinterface

[sv/pcm_decode_downmix_hop_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_decode_downmix_hop_framer_unit
// Decodes interleaved little-endian pcm bytes, averages each frame to one
// Q1.31 mono sample and marks the last sample of every hop group.
// ----------------------------------------------------------------------------
//  channel  role    word
//  pcm      sink    data_byte[7:0], stream_end
//  mono     source  mono_sample[31:0] signed, last_of_hop
//  cfg      write   cfg_en, cfg_index[1:0], cfg_data[15:0]
//
//  The front takes one byte word per cycle while the frame queue has room.
//  A single-channel frame is taken and written to the output register in the
//  same cycle, once that register is free; a frame of two or more channels
//  holds the back through the radix-16 divider steps and the send state.
//  Synchronous reset clears all partial state and loads register defaults.
//  A stalled mono word sits in the output register; the back stops at its
//  next mono word while the front keeps working until the queue fills.
module pcm_decode_downmix_hop_framer_unit #(
  parameter int MAX_CHANNELS = pcmdm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  pcmdm_in_if.sink                         pcm,
  pcmdm_out_if.source                      mono,
  input  logic                             cfg_en,
  input  logic [pcmdm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcmdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcmdm_pkg::*;

  localparam int SUM_W  = 32 + $clog2(MAX_CHANNELS);
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int ITEM_W = 1 + SUM_W + CNT_W;

  logic [3:0]  channel_count;
  logic [5:0]  sample_bits;
  logic [15:0] hop_length;

  logic              f_valid, f_ready;
  logic [ITEM_W-1:0] f_data;
  logic              b_valid, b_ready;
  logic [ITEM_W-1:0] b_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      sample_bits   <= SAMPLE_BITS_RST;
      hop_length    <= HOP_LENGTH_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
        REG_SAMPLE_BITS:   sample_bits   <= cfg_data[5:0];
        REG_HOP_LENGTH:    hop_length    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // byte assembly and frame summing
  pcmdm_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W),
    .ITEM_W       (ITEM_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .pcm           (pcm),
    .channel_count (channel_count),
    .sample_bits   (sample_bits),
    .q_valid       (f_valid),
    .q_data        (f_data),
    .q_ready       (f_ready)
  );

  // frame queue
  pcmdm_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_data   (b_data),
    .pop_ready  (b_ready)
  );

  // averaging and hop framing
  pcmdm_back #(
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W),
    .ITEM_W (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_data     (b_data),
    .q_ready    (b_ready),
    .hop_length (hop_length),
    .mono       (mono)
  );

endmodule

[sv/pcmdm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdm_front
// Takes one pcm byte word a cycle, queue permitting; assembles samples,
// left-aligns them, sums each frame and queues frames and stream-end marks.
// ----------------------------------------------------------------------------
module pcmdm_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int SUM_W        = 35,
  parameter int CNT_W        = 4,
  parameter int ITEM_W       = 40
) (
  input  logic              clk,
  input  logic              rst,
  pcmdm_in_if.sink          pcm,
  input  logic [3:0]        channel_count,
  input  logic [5:0]        sample_bits,
  output logic              q_valid,
  output logic [ITEM_W-1:0] q_data,
  input  logic              q_ready
);
  import pcmdm_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [1:0]              byte_position;
  logic [31:0]             sample_assembly;
  logic [CH_W-1:0]         channel_position;
  logic signed [SUM_W-1:0] frame_sum;

  logic [2:0]              n_bytes;
  logic [CNT_W-1:0]        n_chans;
  logic [31:0]             asm_full;
  logic signed [31:0]      aligned;
  logic signed [SUM_W-1:0] sum_full;
  logic                    last_byte;
  logic                    last_chan;
  logic                    accept;

  // effective byte count and channel count
  always_comb begin
    if (sample_bits[5:3] == 3'd0) begin
      n_bytes = 3'd1;
    end else if (sample_bits[5:3] > 3'd4) begin
      n_bytes = 3'd4;
    end else begin
      n_bytes = sample_bits[5:3];
    end
    if (channel_count == 4'd0) begin
      n_chans = CNT_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      n_chans = CNT_W'(MAX_CHANNELS);
    end else begin
      n_chans = CNT_W'(channel_count);
    end
  end

  // sample assembly and left alignment
  always_comb begin
    asm_full = sample_assembly | (32'(pcm.data_byte) << {byte_position, 3'b000});
    case (n_bytes)
      3'd1:    aligned = {asm_full[7:0] ^ 8'h80, 24'h000000};
      3'd2:    aligned = {asm_full[15:0], 16'h0000};
      3'd3:    aligned = {asm_full[23:0], 8'h00};
      default: aligned = asm_full;
    endcase
    sum_full  = frame_sum + SUM_W'(aligned);
    last_byte = ({1'b0, byte_position} + 3'd1) >= n_bytes;
    last_chan = (32'(channel_position) + 1) >= 32'(n_chans);
  end

  assign pcm.ready = q_ready;
  assign accept    = pcm.valid && q_ready;

  // queue push: a finished frame or a stream-end mark
  always_comb begin
    q_valid = accept && (pcm.stream_end || (last_byte && last_chan));
    if (pcm.stream_end) begin
      q_data = {1'b1, {(ITEM_W-1){1'b0}}};
    end else begin
      q_data = {1'b0, sum_full, n_chans};
    end
  end

  // partial frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      sample_assembly  <= '0;
      channel_position <= '0;
      frame_sum        <= '0;
    end else if (accept) begin
      if (pcm.stream_end) begin
        byte_position    <= '0;
        sample_assembly  <= '0;
        channel_position <= '0;
        frame_sum        <= '0;
      end else if (!last_byte) begin
        byte_position   <= byte_position + 2'd1;
        sample_assembly <= asm_full;
      end else begin
        byte_position   <= '0;
        sample_assembly <= '0;
        if (!last_chan) begin
          channel_position <= channel_position + CH_W'(1);
          frame_sum        <= sum_full;
        end else begin
          channel_position <= '0;
          frame_sum        <= '0;
        end
      end
    end
  end

endmodule

[sv/pcmdm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdm_queue
// Short register queue of frame words between front and back.
// ----------------------------------------------------------------------------
module pcmdm_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);
  import pcmdm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (32'(fill) < DEPTH);
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

[sv/pcmdm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdm_back
// Divides each frame sum by its channel count (radix-16 iterative divider,
// truncation toward zero), counts hop groups and holds the output register.
// ----------------------------------------------------------------------------
module pcmdm_back #(
  parameter int SUM_W  = 35,
  parameter int CNT_W  = 4,
  parameter int ITEM_W = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [ITEM_W-1:0] q_data,
  output logic              q_ready,
  input  logic [15:0]       hop_length,
  pcmdm_out_if.source       mono
);
  import pcmdm_pkg::*;

  localparam int DIV_STEPS = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DW        = DIV_STEPS * DIV_RADIX_BITS;
  localparam int ITER_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  back_state_t state, state_next;

  logic [DW-1:0]     dq, dq_next, dq_step;
  logic [CNT_W-1:0]  rem, rem_next, rem_step;
  logic [CNT_W-1:0]  divisor, divisor_next;
  logic              neg, neg_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [15:0]       hop_fill, hop_fill_next;

  logic              out_valid, out_valid_next;
  logic signed [31:0] out_sample, out_sample_next;
  logic              out_last, out_last_next;

  // head of queue
  logic                    h_end;
  logic signed [SUM_W-1:0] h_sum;
  logic [CNT_W-1:0]        h_chans;
  logic [SUM_W-1:0]        h_mag;

  logic              out_free;
  logic              emit;
  logic [31:0]       emit_val;
  logic [31:0]       quot;
  logic [16:0]       fill_inc;
  logic [16:0]       hop_eff;
  logic              hop_done;

  assign h_end   = q_data[ITEM_W-1];
  assign h_sum   = q_data[SUM_W+CNT_W-1:CNT_W];
  assign h_chans = q_data[CNT_W-1:0];
  assign h_mag   = h_sum[SUM_W-1] ? SUM_W'(-h_sum) : SUM_W'(h_sum);

  assign out_free = !out_valid || mono.ready;
  assign quot     = neg ? (32'd0 - dq[31:0]) : dq[31:0];

  assign mono.valid       = out_valid;
  assign mono.mono_sample = out_sample;
  assign mono.last_of_hop = out_last;

  // one divider cycle: DIV_RADIX_BITS restoring steps on a narrow remainder
  always_comb begin
    logic [CNT_W:0] r;
    logic [DW-1:0]  d;
    d = dq;
    r = {1'b0, rem};
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r = {r[CNT_W-1:0], d[DW-1]};
      d = {d[DW-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        d[0] = 1'b1;
      end
    end
    dq_step  = d;
    rem_step = r[CNT_W-1:0];
  end

  // hop group count
  always_comb begin
    fill_inc = {1'b0, hop_fill} + 17'd1;
    hop_eff  = (hop_length == 16'd0) ? 17'd1 : {1'b0, hop_length};
    hop_done = fill_inc >= hop_eff;
  end

  // sequencer: next state and datapath controls
  always_comb begin
    state_next      = state;
    dq_next         = dq;
    rem_next        = rem;
    divisor_next    = divisor;
    neg_next        = neg;
    iter_next       = iter;
    hop_fill_next   = hop_fill;
    q_ready         = 1'b0;
    emit            = 1'b0;
    emit_val        = quot;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (h_end) begin
            q_ready       = 1'b1;
            hop_fill_next = '0;
          end else if (h_chans == CNT_W'(1)) begin
            if (out_free) begin
              q_ready  = 1'b1;
              emit     = 1'b1;
              emit_val = h_sum[31:0];
            end
          end else begin
            q_ready      = 1'b1;
            dq_next      = DW'(h_mag);
            rem_next     = '0;
            divisor_next = h_chans;
            neg_next     = h_sum[SUM_W-1];
            iter_next    = '0;
            state_next   = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        dq_next   = dq_step;
        rem_next  = rem_step;
        iter_next = iter + ITER_W'(1);
        if (32'(iter) == DIV_STEPS - 1) begin
          state_next = BK_SEND;
        end
      end
      BK_SEND: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase

    // output register
    out_valid_next  = out_valid && !mono.ready;
    out_sample_next = out_sample;
    out_last_next   = out_last;
    if (emit) begin
      out_valid_next  = 1'b1;
      out_sample_next = emit_val;
      out_last_next   = hop_done;
      hop_fill_next   = hop_done ? 16'd0 : fill_inc[15:0];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      hop_fill  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hop_fill  <= hop_fill_next;
      out_valid <= out_valid_next;
    end
  end

  // divider and output payload
  always_ff @(posedge clk) begin
    dq         <= dq_next;
    rem        <= rem_next;
    divisor    <= divisor_next;
    neg        <= neg_next;
    iter       <= iter_next;
    out_sample <= out_sample_next;
    out_last   <= out_last_next;
  end

endmodule

[tb/tb_pcm_decode_downmix_hop_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_decode_downmix_hop_framer_unit
// Self-checking bench for the pcm decode / downmix hop framer. Byte words go
// in through a queued driver and mono words come back through a monitor.
// An in-bench decoder predicts every mono word and hop flag from the
// accepted byte words and a shadow copy of the registers. Registers are
// rewritten between phases, often while a sample or frame is half built.
// ----------------------------------------------------------------------------
module tb_pcm_decode_downmix_hop_framer_unit;
  import pcmdm_pkg::*;

  localparam int MAX_FRAME    = MAX_CHANNELS_DEF;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_LIMIT   = 4000;
  localparam int REPORT_LIMIT = 40;
  localparam int ITEM_TARGET  = 1325;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } pcm_item_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        hop_end;
  } mono_word_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pcmdm_in_if  pcm_bus ();
  pcmdm_out_if mono_bus ();

  pcm_decode_downmix_hop_framer_unit #(
    .MAX_CHANNELS(MAX_FRAME)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .pcm      (pcm_bus),
    .mono     (mono_bus),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow registers
  logic [3:0]  reg_channels;
  logic [5:0]  reg_bits;
  logic [15:0] reg_hop;

  // decoder state
  logic [1:0]         byte_pos;
  logic [31:0]        assembly;
  logic [2:0]         chan_pos;
  logic signed [34:0] frame_sum;
  logic [15:0]        hop_fill;

  pcm_item_t  pcm_backlog[$];
  mono_word_t pending_mono[$];
  pcm_item_t  pcm_next;
  mono_word_t want;

  bit pcm_fire;
  bit mono_fire;
  bit pcm_calm;
  bit mono_calm;
  int pcm_gap;
  int mono_stall;
  int idle_cycles;
  int fail_count;
  int items_queued;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int width_bytes();
    int b;
    b = int'(reg_bits) >> 3;
    if (b < 1) b = 1;
    else if (b > 4) b = 4;
    return b;
  endfunction

  function automatic int frame_width();
    int c;
    c = int'(reg_channels);
    if (c < 1) c = 1;
    else if (c > MAX_FRAME) c = MAX_FRAME;
    return c;
  endfunction

  function automatic void reset_decoder_state();
    byte_pos  = '0;
    assembly  = '0;
    chan_pos  = '0;
    frame_sum = '0;
    hop_fill  = '0;
  endfunction

  // one accepted byte word: build sample, sum frame, average, flag hop end
  function automatic void decode_pcm_byte(input logic [7:0] data, input logic eos);
    int                 nbytes;
    int                 nchan;
    int                 hop;
    logic [31:0]        aligned;
    logic signed [34:0] avg;
    mono_word_t         word;
    if (eos) begin
      reset_decoder_state();
      return;
    end
    nbytes = width_bytes();
    assembly = assembly | ({24'd0, data} << (8 * byte_pos));
    if (byte_pos + 1 < nbytes) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    // single byte samples are offset binary
    if (nbytes == 1) aligned = (assembly ^ 32'h80) << 24;
    else aligned = assembly << (32 - 8 * nbytes);
    byte_pos = '0;
    assembly = '0;
    frame_sum = frame_sum + {{3{aligned[31]}}, aligned};
    nchan = frame_width();
    if (chan_pos + 1 < nchan) begin
      chan_pos = chan_pos + 3'd1;
      return;
    end
    // signed divide truncates toward zero
    avg = frame_sum / 35'(nchan);
    chan_pos = '0;
    frame_sum = '0;
    hop = (reg_hop == 16'd0) ? 1 : int'(reg_hop);
    hop_fill = hop_fill + 16'd1;
    word.sample = avg[31:0];
    word.hop_end = 1'b0;
    if (hop_fill >= hop) begin
      word.hop_end = 1'b1;
      hop_fill = '0;
    end
    pending_mono.push_back(word);
  endfunction

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
  endtask

  // accept detection, prediction, checking and watchdog
  always @(posedge clk) begin
    pcm_fire  = !rst && pcm_bus.valid && pcm_bus.ready;
    mono_fire = !rst && mono_bus.valid && mono_bus.ready;
    if (pcm_fire) decode_pcm_byte(pcm_bus.data_byte, pcm_bus.stream_end);
    if (mono_fire) begin
      if (pending_mono.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected mono word %h, last_of_hop %b", $time,
                   mono_bus.mono_sample, mono_bus.last_of_hop);
      end else begin
        want = pending_mono.pop_front();
        if (mono_bus.mono_sample !== want.sample)
          report_mismatch("mono_sample", want.sample, mono_bus.mono_sample);
        if (mono_bus.last_of_hop !== want.hop_end)
          report_mismatch("last_of_hop", {31'd0, want.hop_end}, {31'd0, mono_bus.last_of_hop});
      end
    end
    if (rst || pcm_fire || mono_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // byte word driver
  always @(negedge clk) begin
    if (rst) begin
      pcm_bus.valid <= 1'b0;
    end else if (!pcm_bus.valid || pcm_fire) begin
      if (pcm_gap > 0) begin
        pcm_bus.valid <= 1'b0;
        pcm_gap = pcm_gap - 1;
      end else if (pcm_backlog.size() > 0) begin
        pcm_next = pcm_backlog.pop_front();
        pcm_bus.valid      <= 1'b1;
        pcm_bus.data_byte  <= pcm_next.data;
        pcm_bus.stream_end <= pcm_next.eos;
        pcm_gap = idle_draw(pcm_calm);
      end else begin
        pcm_bus.valid <= 1'b0;
      end
    end
  end

  // mono word back pressure
  always @(negedge clk) begin
    if (rst) begin
      mono_bus.ready <= 1'b0;
    end else begin
      if (mono_fire) mono_stall = idle_draw(mono_calm);
      if (mono_stall > 0) begin
        mono_bus.ready <= 1'b0;
        mono_stall = mono_stall - 1;
      end else begin
        mono_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [7:0] data, input logic eos);
    pcm_backlog.push_back('{data: data, eos: eos});
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_CHANNEL_COUNT: reg_channels = value[3:0];
      REG_SAMPLE_BITS:   reg_bits = value[5:0];
      REG_HOP_LENGTH:    reg_hop = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  // all words in and out, then let the back end settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pcm_backlog.size() != 0 || pcm_bus.valid || pending_mono.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // whole frames at the current format, extremes mixed with random content
  task automatic queue_frames(input int frames);
    int          nbytes;
    int          nchan;
    logic [31:0] word;
    nbytes = width_bytes();
    nchan = frame_width();
    for (int f = 0; f < frames; f++) begin
      for (int c = 0; c < nchan; c++) begin
        case ($urandom_range(0, 9))
          0: word = 32'h0000_0000;
          1: word = 32'hFFFF_FFFF;
          2: word = 32'h8000_0000 >> (32 - 8 * nbytes);
          3: word = 32'h7FFF_FFFF >> (32 - 8 * nbytes);
          default: word = $urandom();
        endcase
        for (int k = 0; k < nbytes; k++) begin
          // rare stream end that breaks the frame
          if ($urandom_range(0, 99) == 0) push_item(8'($urandom()), 1'b1);
          push_item(word[8*k +: 8], 1'b0);
        end
      end
    end
  endtask

  // stimulus
  initial begin
    int              ch;
    int              bits;
    int              hop;
    int              junk;
    logic [15:0]     cfg_value;
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pcm_bus.valid = 1'b0;
    pcm_bus.data_byte = '0;
    pcm_bus.stream_end = 1'b0;
    mono_bus.ready = 1'b0;
    reg_channels = CHANNEL_COUNT_RST;
    reg_bits = SAMPLE_BITS_RST;
    reg_hop = HOP_LENGTH_RST;
    reset_decoder_state();
    pcm_calm = 1'b0;
    mono_calm = 1'b0;
    pcm_gap = 0;
    mono_stall = 0;
    idle_cycles = 0;
    fail_count = 0;
    items_queued = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset format, 16-bit mono: full-scale negative, maximum, minus one
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hA5, 1'b1);
    wait_idle();

    // 8-bit stereo, hop length zero flags every word, stream end mid frame
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    write_reg(REG_SAMPLE_BITS, 16'd8);
    write_reg(REG_HOP_LENGTH, 16'd0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'h00, 1'b1);
    wait_idle();

    // 24-bit, three channels: negative sum truncates toward zero
    write_reg(REG_CHANNEL_COUNT, 16'd3);
    write_reg(REG_SAMPLE_BITS, 16'd24);
    write_reg(REG_HOP_LENGTH, 16'd2);
    repeat (6) push_item(8'hFF, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    // leave a sample half built
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b0);
    wait_idle();

    // odd width mid sample: byte position beyond the new limit closes it
    write_reg(REG_SAMPLE_BITS, 16'd7);
    push_item(8'h12, 1'b0);
    wait_idle();

    // channel count zero mid frame closes the frame
    write_reg(REG_CHANNEL_COUNT, 16'd0);
    push_item(8'h34, 1'b0);
    wait_idle();

    // random phases, registers rewritten with partial state left in place
    while (items_queued < ITEM_TARGET) begin
      pcm_calm = ($urandom_range(0, 3) == 0);
      mono_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 11))
        0: ch = 0;
        1: ch = $urandom_range(MAX_FRAME + 1, 15);
        2: ch = MAX_FRAME;
        default: ch = $urandom_range(1, MAX_FRAME);
      endcase
      case ($urandom_range(0, 9))
        0: bits = $urandom_range(0, 63);
        default: bits = 8 * $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0: hop = 0;
        1: hop = 16'hFFFF;
        2: hop = $urandom_range(0, 65535);
        default: hop = $urandom_range(1, 6);
      endcase
      // unused upper data bits now and then
      junk = ($urandom_range(0, 3) == 0) ? $urandom() : 0;
      cfg_value = 16'((junk << 4) | ch);
      write_reg(REG_CHANNEL_COUNT, cfg_value);
      cfg_value = 16'((junk << 6) | bits);
      write_reg(REG_SAMPLE_BITS, cfg_value);
      write_reg(REG_HOP_LENGTH, 16'(hop));
      if ($urandom_range(0, 2) == 0) push_item(8'($urandom()), 1'b1);
      queue_frames($urandom_range(2, 12));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5)) push_item(8'($urandom()), 1'b0);
      wait_idle();
    end

    if (pending_mono.size() != 0) begin
      fail_count++;
      $display("%0t: %0d mono words never arrived", $time, pending_mono.size());
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
